### sv/pgs_pkg.sv
// pgs_pkg: shared widths, request and response structs, command struct and the sine table
// for the path gear segmenter; no dependencies
`default_nettype none
package pgs_pkg;

   localparam int COORD_WIDTH         = 32;
   localparam int ANGLE_WIDTH         = 16;
   localparam int SINE_TABLE_DEPTH    = 1024;
   localparam int SEGMENT_COUNT_WIDTH = 8;

   localparam int SINE_WIDTH       = 17;
   localparam int SINE_INDEX_WIDTH = $clog2(SINE_TABLE_DEPTH);
   localparam int DIFF_WIDTH       = COORD_WIDTH + 1;
   localparam int STEP_SHIFT       = (COORD_WIDTH > 46) ? (COORD_WIDTH - 46) : 0;
   localparam int PROD_WIDTH       = DIFF_WIDTH + SINE_WIDTH;

   localparam int QUEUE_DEPTH       = 8;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SEGMENT_COUNT_WIDTH-1:0] SEG_MAX = '1;

   localparam longint unsigned COEF_A = 64'd1686629713;
   localparam longint unsigned COEF_B = 64'd693598342;
   localparam longint unsigned COEF_C = 64'd85569015;
   localparam longint unsigned COEF_D = 64'd5026951;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic [ANGLE_WIDTH-1:0]        heading;
      logic                          final_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0]  out_x;
      logic signed [COORD_WIDTH-1:0]  out_y;
      logic [ANGLE_WIDTH-1:0]         out_heading;
      logic                           gear;
      logic [SEGMENT_COUNT_WIDTH-1:0] segment_number;
      logic                           segment_end;
      logic                           path_end;
      logic                           too_short;
   } rsp_type;

   // one classified step: held point, new point and the gear of the held point
   typedef struct packed {
      logic                          too_short;
      logic                          final_point;
      logic                          gear;
      logic signed [COORD_WIDTH-1:0] held_x;
      logic signed [COORD_WIDTH-1:0] held_y;
      logic [ANGLE_WIDTH-1:0]        held_heading;
      logic signed [COORD_WIDTH-1:0] new_x;
      logic signed [COORD_WIDTH-1:0] new_y;
      logic [ANGLE_WIDTH-1:0]        new_heading;
   } cmd_type;

   typedef logic signed [SINE_WIDTH-1:0] sine_table_type [SINE_TABLE_DEPTH];

   // q15 sine over a full turn, polynomial in q30 with horner steps
   function automatic sine_table_type make_sine_table();
      sine_table_type  tab;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      for (int p = 0; p < SINE_TABLE_DEPTH; p++) begin
         u  = (longint'(p) << 30) / SINE_TABLE_DEPTH;
         q  = (u >> 28) & 64'd3;
         r  = u & ((64'd1 << 28) - 64'd1);
         if (q[0]) begin
            r = (64'd1 << 28) - r;
         end
         x2 = (r * r) >> 28;
         t  = COEF_C - ((x2 * COEF_D) >> 28);
         t  = COEF_B - ((x2 * t) >> 28);
         t  = COEF_A - ((x2 * t) >> 28);
         s  = ((r * t) >> 28) >> 15;
         tab[p] = (q >= 64'd2) ? -SINE_WIDTH'(s) : SINE_WIDTH'(s);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = make_sine_table();

endpackage
`default_nettype wire

### sv/pgs_front.sv
// pgs_front: accepts path points, holds the previous point and classifies each step
// as drive or reverse in a short pipeline; uses pgs_pkg
`default_nettype none
module pgs_front
   import pgs_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output      logic                         req_full,
   input  wire req_type                      req_data,
   input  wire logic [QUEUE_LEVEL_WIDTH-1:0] queue_level,
   output      logic                         cmd_push,
   output      cmd_type                      cmd_data
);

   logic                          accept;
   logic                          makes_cmd;
   logic                          have_held_ff, have_held_in;
   logic signed [COORD_WIDTH-1:0] held_x_ff, held_y_ff;
   logic [ANGLE_WIDTH-1:0]        held_heading_ff;

   logic [ANGLE_WIDTH+SINE_INDEX_WIDTH-1:0] angle_scaled;
   logic [SINE_INDEX_WIDTH-1:0]             sin_index, cos_index;
   cmd_type                                 cmd_new;

   logic                          s1_valid_ff;
   cmd_type                       s1_cmd_ff;
   logic signed [DIFF_WIDTH-1:0]  s1_dx_ff, s1_dy_ff, dx_in, dy_in, dx_sh, dy_sh;
   logic signed [SINE_WIDTH-1:0]  s1_sin_ff, s1_cos_ff;

   logic                          s2_valid_ff;
   cmd_type                       s2_cmd_ff;
   logic signed [PROD_WIDTH-1:0]  s2_px_ff, s2_py_ff;
   logic                          s2_zero_ff, s2_cos_pos_ff;
   logic signed [PROD_WIDTH:0]    dot;

   logic [QUEUE_LEVEL_WIDTH:0]    occupancy;

   // queue slots promised to steps still in the pipeline count as taken
   assign occupancy = {1'b0, queue_level} + (QUEUE_LEVEL_WIDTH + 1)'(s1_valid_ff)
                      + (QUEUE_LEVEL_WIDTH + 1)'(s2_valid_ff);
   assign req_full  = occupancy >= (QUEUE_LEVEL_WIDTH + 1)'(QUEUE_DEPTH);
   assign accept    = req_push && !req_full;
   assign makes_cmd = accept && (have_held_ff || req_data.final_point);

   assign angle_scaled = {held_heading_ff, SINE_INDEX_WIDTH'(0)};
   assign sin_index    = angle_scaled[ANGLE_WIDTH+SINE_INDEX_WIDTH-1 -: SINE_INDEX_WIDTH];
   assign cos_index    = sin_index + SINE_INDEX_WIDTH'(SINE_TABLE_DEPTH / 4);

   assign dx_in = DIFF_WIDTH'(req_data.pos_x) - DIFF_WIDTH'(held_x_ff);
   assign dy_in = DIFF_WIDTH'(req_data.pos_y) - DIFF_WIDTH'(held_y_ff);
   assign dx_sh = s1_dx_ff >>> STEP_SHIFT;
   assign dy_sh = s1_dy_ff >>> STEP_SHIFT;

   always_comb begin
      cmd_new              = '0;
      cmd_new.too_short    = !have_held_ff;
      cmd_new.final_point  = req_data.final_point;
      cmd_new.held_x       = held_x_ff;
      cmd_new.held_y       = held_y_ff;
      cmd_new.held_heading = held_heading_ff;
      cmd_new.new_x        = req_data.pos_x;
      cmd_new.new_y        = req_data.pos_y;
      cmd_new.new_heading  = req_data.heading;
      have_held_in         = have_held_ff;
      if (accept) begin
         have_held_in = !req_data.final_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_held_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         have_held_ff <= have_held_in;
         s1_valid_ff  <= makes_cmd;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_x_ff       <= req_data.pos_x;
         held_y_ff       <= req_data.pos_y;
         held_heading_ff <= req_data.heading;
      end
      s1_cmd_ff     <= cmd_new;
      s1_dx_ff      <= dx_in;
      s1_dy_ff      <= dy_in;
      s1_sin_ff     <= SINE_TABLE[sin_index];
      s1_cos_ff     <= SINE_TABLE[cos_index];
      s2_cmd_ff     <= s1_cmd_ff;
      s2_px_ff      <= PROD_WIDTH'(dx_sh) * PROD_WIDTH'(s1_cos_ff);
      s2_py_ff      <= PROD_WIDTH'(dy_sh) * PROD_WIDTH'(s1_sin_ff);
      s2_zero_ff    <= (s1_dx_ff == '0) && (s1_dy_ff == '0);
      s2_cos_pos_ff <= s1_cos_ff > 0;
   end

   assign dot = (PROD_WIDTH + 1)'(s2_px_ff) + (PROD_WIDTH + 1)'(s2_py_ff);

   always_comb begin
      cmd_data      = s2_cmd_ff;
      cmd_data.gear = s2_zero_ff ? s2_cos_pos_ff : (dot > 0);
   end

   assign cmd_push = s2_valid_ff;

endmodule
`default_nettype wire

### sv/pgs_queue.sv
// pgs_queue: short queue of classified steps between front and back
// uses pgs_pkg
`default_nettype none
module pgs_queue
   import pgs_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire cmd_type                      push_data,
   input  wire logic                         pop,
   output      logic                         head_valid,
   output      cmd_type                      head_data,
   output      logic [QUEUE_LEVEL_WIDTH-1:0] level
);

   cmd_type                      slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = level_ff != '0;
   assign head_data  = slots_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule
`default_nettype wire

### sv/pgs_back.sv
// pgs_back: turns each classified step into one to three responses and keeps
// the segment gear and count; uses pgs_pkg
`default_nettype none
module pgs_back
   import pgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire cmd_type head_data,
   output      logic    head_pop,
   output      logic    rsp_empty,
   input  wire logic    rsp_pop,
   output      rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_HEAD  = 3'b001,
      ST_OPEN  = 3'b010,
      ST_FINAL = 3'b100
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic                           gear_known_ff, gear_known_in;
   logic                           running_gear_ff, running_gear_in;
   logic [SEGMENT_COUNT_WIDTH-1:0] segment_ff, segment_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;
   logic                           slot_free;
   logic                           first_gear;
   logic [SEGMENT_COUNT_WIDTH-1:0] first_segment;

   assign slot_free     = !rsp_valid_ff || rsp_pop;
   assign first_gear    = gear_known_ff ? running_gear_ff : head_data.gear;
   assign first_segment = gear_known_ff ? segment_ff : '0;

   always_comb begin
      state_in        = state_ff;
      gear_known_in   = gear_known_ff;
      running_gear_in = running_gear_ff;
      segment_in      = segment_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      head_pop        = 1'b0;
      if (head_valid && slot_free) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.out_x       = head_data.held_x;
         rsp_in.out_y       = head_data.held_y;
         rsp_in.out_heading = head_data.held_heading;
         unique case (state_ff)
            ST_HEAD: begin
               if (head_data.too_short) begin
                  rsp_in.out_x       = head_data.new_x;
                  rsp_in.out_y       = head_data.new_y;
                  rsp_in.out_heading = head_data.new_heading;
                  rsp_in.path_end    = 1'b1;
                  rsp_in.too_short   = 1'b1;
                  gear_known_in      = 1'b0;
                  running_gear_in    = 1'b0;
                  segment_in         = '0;
                  head_pop           = 1'b1;
               end else if (gear_known_ff && (head_data.gear != running_gear_ff)) begin
                  // gear change: close the old segment first
                  rsp_in.gear           = running_gear_ff;
                  rsp_in.segment_number = segment_ff;
                  rsp_in.segment_end    = 1'b1;
                  if (segment_ff != SEG_MAX) begin
                     segment_in = segment_ff + 1'b1;
                  end
                  running_gear_in = head_data.gear;
                  state_in        = ST_OPEN;
               end else begin
                  rsp_in.gear           = first_gear;
                  rsp_in.segment_number = first_segment;
                  gear_known_in         = 1'b1;
                  running_gear_in       = first_gear;
                  segment_in            = first_segment;
                  if (head_data.final_point) begin
                     state_in = ST_FINAL;
                  end else begin
                     head_pop = 1'b1;
                  end
               end
            end
            ST_OPEN: begin
               rsp_in.gear           = running_gear_ff;
               rsp_in.segment_number = segment_ff;
               if (head_data.final_point) begin
                  state_in = ST_FINAL;
               end else begin
                  head_pop = 1'b1;
                  state_in = ST_HEAD;
               end
            end
            ST_FINAL: begin
               rsp_in.out_x          = head_data.new_x;
               rsp_in.out_y          = head_data.new_y;
               rsp_in.out_heading    = head_data.new_heading;
               rsp_in.gear           = running_gear_ff;
               rsp_in.segment_number = segment_ff;
               rsp_in.segment_end    = 1'b1;
               rsp_in.path_end       = 1'b1;
               gear_known_in         = 1'b0;
               running_gear_in       = 1'b0;
               segment_in            = '0;
               head_pop              = 1'b1;
               state_in              = ST_HEAD;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_pop;
               rsp_in       = rsp_ff;
               state_in     = ST_HEAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_HEAD;
         gear_known_ff   <= 1'b0;
         running_gear_ff <= 1'b0;
         segment_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         gear_known_ff   <= gear_known_in;
         running_gear_ff <= running_gear_in;
         segment_ff      <= segment_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### sv/path_gear_segmenter.sv
// path_gear_segmenter: top level, front classifier, step queue and response sequencer
// uses pgs_pkg, pgs_front, pgs_queue, pgs_back
//
//   channel     ports                          moves
//   request     req_push, req_full, req_data   one path point (req_type)
//   response    rsp_empty, rsp_pop, rsp_data   one emitted point (rsp_type)
//
// a request is taken every cycle while req_full is low; classification is pipelined
// (table lookup and differences, then products, then sign of the dot product)
// the response sequencer gives one response a cycle while steps wait and the receiver pops:
// one response per point on a steady gear, two on a gear change and one more on the last point
// req_full rises when the eight entry step queue plus steps in flight is full
// reset is synchronous and clears all control state; no clearing pass
`default_nettype none
module path_gear_segmenter
   import pgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output      logic    req_full,
   input  wire req_type req_data,
   output      logic    rsp_empty,
   input  wire logic    rsp_pop,
   output      rsp_type rsp_data
);

   // front to queue
   logic                         cmd_push;
   cmd_type                      cmd_data;
   logic [QUEUE_LEVEL_WIDTH-1:0] queue_level;

   // queue to back
   logic                         head_valid;
   cmd_type                      head_data;
   logic                         head_pop;

   // holds the previous point and decides the gear of each step
   pgs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .queue_level (queue_level),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_data)
   );

   // lets the front keep taking points while the back expands gear changes
   pgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .level      (queue_level)
   );

   // segment bookkeeping and the response register
   pgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

### sv/pgs_checker.sv
// pgs_checker: port level checks of the path gear segmenter, bound to the top level
// uses pgs_pkg
`default_nettype none
module pgs_checker
   import pgs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   // a waiting response stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing is left over after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("block not empty after reset");

   // the error response is a bare path end
   a_short_form: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.too_short |->
         rsp_data.path_end && !rsp_data.segment_end && !rsp_data.gear
         && (rsp_data.segment_number == '0))
      else $error("malformed error response");

   // a segment that closes before the path end is reopened with the next segment number
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_data.segment_end && !rsp_data.path_end
         && (rsp_data.segment_number != SEG_MAX) |=>
         rsp_empty || (rsp_data.segment_number == $past(rsp_data.segment_number) + 1'b1))
      else $error("segment number did not advance on gear change");

endmodule

bind path_gear_segmenter pgs_checker u_pgs_checker (.*);
`default_nettype wire

### sim/path_gear_segmenter_check.sv
// path_gear_segmenter_check: watches the request and response channels of the path gear
// segmenter, predicts the emitted points of each accepted request and compares them
// depends on pgs_pkg for widths, coefficients and the request and response structs
`timescale 1ns / 1ps
module path_gear_segmenter_check
   import pgs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      awaited_count,
   output int      points_checked,
   output int      gear_changes,
   output int      single_point_paths,
   output int      saturated_paths
);

   localparam int QUARTER_TURN = SINE_TABLE_DEPTH / 4;

   longint  sine_q15 [SINE_TABLE_DEPTH];
   rsp_type awaited_points [$];

   // predicted path state
   logic signed [COORD_WIDTH-1:0]  held_x;
   logic signed [COORD_WIDTH-1:0]  held_y;
   logic [ANGLE_WIDTH-1:0]         held_heading;
   logic                           holding;
   logic                           gear_set;
   logic                           cur_gear;
   logic [SEGMENT_COUNT_WIDTH-1:0] seg_idx;

   int fails;
   int checked;
   int changes;
   int singles;
   int saturated;

   // q15 sine of table index p, odd quadrants folded, horner steps in q30
   function automatic longint sine_at(input int p);
      longint unsigned frac;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned r2;
      longint unsigned acc;
      frac = p;
      frac = (frac << 30) / SINE_TABLE_DEPTH;
      quad = (frac >> 28) & 64'd3;
      r    = frac & ((64'd1 << 28) - 64'd1);
      if (quad[0]) begin
         r = (64'd1 << 28) - r;
      end
      r2  = (r * r) >> 28;
      acc = COEF_C - ((r2 * COEF_D) >> 28);
      acc = COEF_B - ((r2 * acc) >> 28);
      acc = COEF_A - ((r2 * acc) >> 28);
      acc = ((r * acc) >> 28) >> 15;
      return (quad >= 64'd2) ? -longint'(acc) : longint'(acc);
   endfunction

   initial begin
      for (int p = 0; p < SINE_TABLE_DEPTH; p++) begin
         sine_q15[p] = sine_at(p);
      end
   end

   // drive when the step lies in the half plane ahead of the held heading
   function automatic logic drive_gear(input logic signed [COORD_WIDTH-1:0] x0, y0,
                                       input logic [ANGLE_WIDTH-1:0] h0,
                                       input logic signed [COORD_WIDTH-1:0] x1, y1);
      longint idx;
      longint sn;
      longint cs;
      longint dx;
      longint dy;
      idx = (longint'(h0) * SINE_TABLE_DEPTH) >>> ANGLE_WIDTH;
      sn  = sine_q15[idx];
      cs  = sine_q15[(idx + QUARTER_TURN) % SINE_TABLE_DEPTH];
      dx  = longint'(x1) - longint'(x0);
      dy  = longint'(y1) - longint'(y0);
      if (dx == 0 && dy == 0) begin
         return cs > 0;
      end
      dx = dx >>> STEP_SHIFT;
      dy = dy >>> STEP_SHIFT;
      return (dx * cs + dy * sn) > 0;
   endfunction

   function automatic rsp_type emitted(input logic signed [COORD_WIDTH-1:0] x, y,
                                       input logic [ANGLE_WIDTH-1:0] h,
                                       input logic g,
                                       input logic [SEGMENT_COUNT_WIDTH-1:0] seg,
                                       input logic closes, ends, lone);
      rsp_type r;
      r.out_x          = x;
      r.out_y          = y;
      r.out_heading    = h;
      r.gear           = g;
      r.segment_number = seg;
      r.segment_end    = closes;
      r.path_end       = ends;
      r.too_short      = lone;
      return r;
   endfunction

   // appends a predicted point behind the ones still awaited
   task automatic await_point(input rsp_type pt);
      awaited_points.insert(awaited_points.size(), pt);
   endtask

   task automatic clear_path();
      held_x       = '0;
      held_y       = '0;
      held_heading = '0;
      holding      = 1'b0;
      gear_set     = 1'b0;
      cur_gear     = 1'b0;
      seg_idx      = '0;
   endtask

   task automatic segment_point(input req_type pt);
      logic step_gear;
      if (!holding) begin
         if (pt.final_point) begin
            await_point(emitted(pt.pos_x, pt.pos_y, pt.heading, 1'b0, '0,
                                1'b0, 1'b1, 1'b1));
            singles++;
         end else begin
            held_x       = pt.pos_x;
            held_y       = pt.pos_y;
            held_heading = pt.heading;
            holding      = 1'b1;
         end
         return;
      end
      step_gear = drive_gear(held_x, held_y, held_heading, pt.pos_x, pt.pos_y);
      if (!gear_set) begin
         cur_gear = step_gear;
         gear_set = 1'b1;
         seg_idx  = '0;
      end else if (step_gear != cur_gear) begin
         // held point closes the old segment, then opens the new one
         await_point(emitted(held_x, held_y, held_heading, cur_gear, seg_idx,
                             1'b1, 1'b0, 1'b0));
         if (seg_idx != SEG_MAX) begin
            seg_idx++;
         end
         cur_gear = step_gear;
         changes++;
      end
      await_point(emitted(held_x, held_y, held_heading, cur_gear, seg_idx,
                          1'b0, 1'b0, 1'b0));
      if (pt.final_point) begin
         await_point(emitted(pt.pos_x, pt.pos_y, pt.heading, cur_gear, seg_idx,
                             1'b1, 1'b1, 1'b0));
         if (seg_idx == SEG_MAX) begin
            saturated++;
         end
         clear_path();
      end else begin
         held_x       = pt.pos_x;
         held_y       = pt.pos_y;
         held_heading = pt.heading;
      end
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fails++;
      end
   endtask

   task automatic check_point(input rsp_type got);
      rsp_type want;
      if (awaited_points.size() == 0) begin
         $display("%0t: response with nothing awaited, expected none, got %h", $time, got);
         fails++;
         return;
      end
      want = awaited_points.pop_front();
      checked++;
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_heading", want.out_heading, got.out_heading);
      compare_field("gear", want.gear, got.gear);
      compare_field("segment_number", want.segment_number, got.segment_number);
      compare_field("segment_end", want.segment_end, got.segment_end);
      compare_field("path_end", want.path_end, got.path_end);
      compare_field("too_short", want.too_short, got.too_short);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_path();
         awaited_points.delete();
      end else begin
         // responses lag requests through the front pipeline and the queue, so the order here is free
         if (rsp_pop && !rsp_empty) begin
            check_point(rsp_data);
         end
         if (req_push && !req_full) begin
            segment_point(req_data);
         end
      end
      fail_count         <= fails;
      awaited_count      <= awaited_points.size();
      points_checked     <= checked;
      gear_changes       <= changes;
      single_point_paths <= singles;
      saturated_paths    <= saturated;
   end

endmodule

### sim/path_gear_segmenter_tb.sv
// path_gear_segmenter_tb: clock, reset and path point stimulus for the path gear segmenter,
// with random idling on both channels and the final verdict
// depends on pgs_pkg, path_gear_segmenter and path_gear_segmenter_check
`timescale 1ns / 1ps
module path_gear_segmenter_tb;
   import pgs_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int RANDOM_POINTS   = 410;
   localparam int ZIGZAG_POINTS   = 265;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int DRAIN_CYCLES    = 16;
   localparam int STALL_LIMIT     = 3000;
   localparam int HALF_TURN       = 1 << (ANGLE_WIDTH - 1);

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int awaited_count;
   int points_checked;
   int gear_changes;
   int single_point_paths;
   int saturated_paths;

   int points_sent   = 0;
   int stall_cycles  = 0;
   bit tx_eager      = 1'b0;
   bit hold_off_go   = 1'b0;
   bit hold_off_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   path_gear_segmenter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   path_gear_segmenter_check u_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data           (req_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_data           (rsp_data),
      .fail_count         (fail_count),
      .awaited_count      (awaited_count),
      .points_checked     (points_checked),
      .gear_changes       (gear_changes),
      .single_point_paths (single_point_paths),
      .saturated_paths    (saturated_paths)
   );

   // mostly back to back, sometimes a short gap, now and then a long one
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type path_point(input logic signed [COORD_WIDTH-1:0] x, y,
                                          input logic [ANGLE_WIDTH-1:0] h,
                                          input logic fin);
      req_type pt;
      pt.pos_x       = x;
      pt.pos_y       = y;
      pt.heading     = h;
      pt.final_point = fin;
      return pt;
   endfunction

   // fully random position and heading, every bit free, never a final point
   function automatic req_type noise_point();
      return path_point(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                        ANGLE_WIDTH'($urandom), 1'b0);
   endfunction

   // next point of a well formed trajectory: heading within 22.5 degrees of the
   // x axis (backwards when aim_back), the step mostly along that axis with a
   // small sideways part, so the gear follows the forward flag
   function automatic req_type step_from(input req_type prev, input bit forward,
                                         input bit aim_back);
      req_type nxt;
      int      mag;
      int      side;
      mag  = $urandom_range(1, 1 << $urandom_range(1, 20));
      side = int'($urandom_range(0, mag / 2)) - mag / 4;
      nxt  = prev;
      // zero step now and then, so the cosine test decides
      if ($urandom_range(0, 19) != 0) begin
         nxt.pos_x = prev.pos_x + ((forward ^ aim_back) ? mag : -mag);
         nxt.pos_y = prev.pos_y + side;
      end
      nxt.heading = ANGLE_WIDTH'(int'(aim_back) * HALF_TURN
                                 + int'($urandom_range(0, HALF_TURN / 4)) - HALF_TURN / 8);
      nxt.final_point = 1'b0;
      return nxt;
   endfunction

   // offer one request and hold it until the block takes it
   task automatic offer_point(input req_type pt);
      int gap;
      req_data <= pt;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      points_sent++;
      gap = tx_eager ? 0 : idle_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pauses until every predicted response has been taken
   task automatic wait_all_results();
      req_push <= 1'b0;
      // the checker's count is registered, so it lags the last request
      @(posedge clock);
      while (awaited_count != 0) begin
         @(posedge clock);
      end
   endtask

   // one path: a lone point, a noisy path or a well formed trajectory
   task automatic offer_random_path();
      req_type pt;
      int      len;
      int      roll;
      bit      aim_back;
      tx_eager = ($urandom_range(0, 9) == 0);
      roll     = $urandom_range(0, 99);
      len      = $urandom_range(2, 14);
      if (roll < 12) begin
         pt             = noise_point();
         pt.final_point = 1'b1;
         offer_point(pt);
      end else if (roll < 35) begin
         pt = noise_point();
         for (int k = 1; k <= len; k++) begin
            // repeat the position now and then for a zero step at any heading
            if ($urandom_range(0, 6) == 0) begin
               pt.heading = ANGLE_WIDTH'($urandom);
            end else begin
               pt = noise_point();
            end
            pt.final_point = (k == len);
            offer_point(pt);
         end
      end else begin
         aim_back = $urandom_range(0, 1);
         pt       = step_from(noise_point(), 1'b1, aim_back);
         offer_point(pt);
         for (int k = 2; k <= len; k++) begin
            pt             = step_from(pt, $urandom_range(0, 99) < 85, aim_back);
            pt.final_point = (k == len);
            offer_point(pt);
         end
      end
   endtask

   // response side: random pops, and once a long hold-off so the block backs up
   initial begin : pop_side
      int gap_left;
      int pops;
      bit eager;
      gap_left = 0;
      pops     = 0;
      eager    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done <= 1'b1;
         end else begin
            if (rsp_pop && !rsp_empty) begin
               pops++;
               // switch between stretches with and without idling
               if (pops % 50 == 0) begin
                  eager = ($urandom_range(0, 2) == 0);
               end
               gap_left = eager ? 0 : idle_gap();
            end
            if (gap_left > 0) begin
               rsp_pop <= 1'b0;
               gap_left--;
            end else begin
               rsp_pop <= 1'b1;
            end
         end
      end
   end

   // watchdog: too many cycles with neither channel moving ends the run
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("watchdog: %0d cycles without a request or response moving", STALL_LIMIT);
      $display("** path_gear_segmenter: FAILED **");
      $finish;
   end

   initial begin : stimulus
      req_type pt;
      int      random_base;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // lone point at the coordinate extremes: too_short response
      offer_point(path_point(COORD_MAX, COORD_MIN, '1, 1'b1));
      // zero steps: cosine positive, negative and exactly zero
      offer_point(path_point(5, 5, '0, 1'b0));
      offer_point(path_point(5, 5, '0, 1'b1));
      offer_point(path_point(-7, 3, ANGLE_WIDTH'(HALF_TURN), 1'b0));
      offer_point(path_point(-7, 3, ANGLE_WIDTH'(HALF_TURN), 1'b1));
      offer_point(path_point(0, 0, ANGLE_WIDTH'(HALF_TURN / 2), 1'b0));
      offer_point(path_point(0, 0, ANGLE_WIDTH'(HALF_TURN / 2), 1'b1));
      // forward, back, forward along x: two gear changes, zero step at the end
      offer_point(path_point(0, 0, '0, 1'b0));
      offer_point(path_point(100, 0, '0, 1'b0));
      offer_point(path_point(50, 0, '0, 1'b0));
      offer_point(path_point(200, 0, '0, 1'b0));
      offer_point(path_point(200, 0, '0, 1'b1));
      // steps spanning the whole coordinate range
      offer_point(path_point(COORD_MIN, COORD_MIN, '0, 1'b0));
      offer_point(path_point(COORD_MAX, COORD_MAX, ANGLE_WIDTH'(HALF_TURN / 4), 1'b0));
      offer_point(path_point(COORD_MIN, COORD_MAX, ANGLE_WIDTH'(3 * HALF_TURN / 2), 1'b0));
      offer_point(path_point(COORD_MAX, COORD_MIN, ANGLE_WIDTH'(3 * HALF_TURN / 4), 1'b1));
      // heading straight up the y axis: the sine decides
      offer_point(path_point(0, 0, ANGLE_WIDTH'(HALF_TURN / 2), 1'b0));
      offer_point(path_point(0, 1000, ANGLE_WIDTH'(HALF_TURN / 2), 1'b0));
      offer_point(path_point(0, -1000, ANGLE_WIDTH'(HALF_TURN / 2), 1'b1));
      wait_all_results();

      random_base = points_sent;
      while (points_sent - random_base < (RANDOM_POINTS - ZIGZAG_POINTS) / 2) begin
         offer_random_path();
      end

      // zigzag path: the gear flips on every step but a zero one, pushing the segment number toward
      // saturation; the receiver holds off meanwhile while requests keep coming
      tx_eager    = 1'b1;
      hold_off_go <= 1'b1;
      pt = step_from(noise_point(), 1'b1, 1'b0);
      offer_point(pt);
      for (int k = 2; k <= ZIGZAG_POINTS; k++) begin
         pt             = step_from(pt, (k % 2) == 0, 1'b0);
         pt.final_point = (k == ZIGZAG_POINTS);
         offer_point(pt);
      end
      wait_all_results();

      while (points_sent - random_base < RANDOM_POINTS) begin
         offer_random_path();
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d points offered, %0d responses checked, %0d gear changes",
               points_sent, points_checked, gear_changes);
      $display("run: %0d single point paths, %0d paths ending on a saturated segment number",
               single_point_paths, saturated_paths);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("** path_gear_segmenter: PASSED **");
      end else begin
         $display("** path_gear_segmenter: FAILED **");
      end
      $finish;
   end

endmodule

### path_gear_segmenter.f
sv/pgs_pkg.sv
sv/pgs_front.sv
sv/pgs_queue.sv
sv/pgs_back.sv
sv/path_gear_segmenter.sv
sv/pgs_checker.sv
sim/path_gear_segmenter_check.sv
sim/path_gear_segmenter_tb.sv
